// ===== hdl/m4inv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4inv_pkg
// Shared constants for the 4x4 adjugate matrix inverse.
// ----------------------------------------------------------------------------
package m4inv_pkg;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

endpackage

// ===== hdl/m4inv_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4inv_ram
// Generic single-port-write, one-port registered-read RAM.
// ----------------------------------------------------------------------------
module m4inv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/m4inv_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4inv_div
// Restoring divider, one quotient bit per cycle, unsigned 64-bit operands.
// ----------------------------------------------------------------------------
module m4inv_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quot
);

    logic [63:0] q_reg;
    logic [64:0] rem_reg;
    logic [63:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [64:0] trial;
    logic [65:0] diff;

    assign trial = {rem_reg[63:0], q_reg[63]};
    assign diff  = {1'b0, trial} - {2'b0, den_reg};
    assign quot  = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                q_reg    <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                if (!diff[65])
                begin
                    rem_reg <= diff[64:0];
                    q_reg   <= {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hdl/m4inv_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4inv_mac
// Shared signed 32x32 multiplier with round-to-nearest (ties away) scaling.
// The product is registered; the rounding that follows it is combinational.
// ----------------------------------------------------------------------------
module m4inv_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] y
);

    logic signed [63:0] p_reg;
    logic        [63:0] mag;
    logic        [63:0] rnd;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign mag = p_reg[63] ? (64'd0 - p_reg) : p_reg;
    assign rnd = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign y   = p_reg[63] ? (64'sd0 - $signed(rnd)) : $signed(rnd);

endmodule

// ===== hdl/matrix4_inverse_adjugate_top.sv =====
`timescale 1ns / 1ps
// After the last element is accepted the determinant is built from four cofactors;
// each result then takes a cofactor pass, a divider start, the divider run and an emit
// (the divider is skipped when the matrix is singular).
// Throughput: one element per cycle while loading; no input accepted during a run.
// The sixteen results leave through a one-entry output register.
// Reset clears the sequencer and handshake state; the matrix store is not cleared.
// ----------------------------------------------------------------------------
// matrix4_inverse_adjugate_top
// Loads a 4x4 Q-format matrix and streams its inverse by cofactors.
// ----------------------------------------------------------------------------
module matrix4_inverse_adjugate_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // elem_row[1:0], elem_col[3:2], elem_value[35:4], pad
    input  logic        s_tlast,  // elem_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // out_row[1:0], out_col[3:2], out_value[35:4], pad
    output logic [1:0]  m_tuser,  // singular[0], saturated[1]
    output logic        m_tlast   // out_last
);

    typedef enum logic [3:0] {
        ST_LOAD, ST_COF, ST_DETACC, ST_DIVSTART, ST_DIVWAIT, ST_EMIT, ST_HOLD
    } state_t;

    state_t state_reg;
    logic        phase_reg;      // 0: determinant pass, 1: output pass
    logic [3:0]  k_reg;          // cofactor index / output index
    logic [4:0]  step_reg;
    logic signed [31:0] a_reg, b_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] m0_reg, m1_reg, m2_reg, cof_reg;
    logic        clip_reg, det_clip_reg;
    logic signed [63:0] det_reg;
    logic        div_start_reg;
    logic [3:0]  raddr;
    logic [31:0] rdata;
    logic signed [63:0] prod;
    logic        div_done;
    logic [63:0] quot;
    logic [1:0]  ci, cj;
    logic [1:0]  rmap [3];
    logic [1:0]  cmap [3];
    logic signed [63:0] sum_sat_in;
    logic signed [63:0] minor_diff;
    logic signed [31:0] minor_sat;

    m4inv_ram #(.WIDTH(32), .DEPTH(16)) u_ram (
        .clk  (clk),
        .we   (s_tvalid && s_tready),
        .waddr({s_tdata[1:0], s_tdata[3:2]}),
        .wdata(s_tdata[35:4]),
        .raddr(raddr),
        .rdata(rdata)
    );

    m4inv_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk(clk), .a(a_reg), .b(b_reg), .y(prod)
    );

    logic [63:0] num_mag, den_mag;
    assign num_mag = cof_reg[31] ? (64'd0 - 64'(cof_reg)) : 64'(cof_reg);
    assign den_mag = det_reg[63] ? (64'd0 - det_reg) : det_reg;

    m4inv_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start_reg),
        .num((num_mag << FRAC_BITS) + (den_mag >> 1)), .den(den_mag),
        .done(div_done), .quot(quot)
    );

    // Cofactor of (ci,cj): determinant pass uses (k,0); output pass uses (col,row).
    assign ci = phase_reg ? k_reg[1:0] : k_reg[1:0];
    assign cj = phase_reg ? k_reg[3:2] : 2'd0;

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            rmap[n] = (2'(n) >= ci) ? 2'(n + 1) : 2'(n);
            cmap[n] = (2'(n) >= cj) ? 2'(n + 1) : 2'(n);
        end
    end

    // Read schedule: step s issues read s; the RAM read port is registered.
    // Element order: s11 s22 s12 s21 | s10 s22 s12 s20 | s10 s21 s11 s20 | s00 s01 s02
    // Step 15 reads A(ci,0); only the determinant pass uses it, as A(k,0).
    always_comb
    begin
        logic [1:0] r, c;
        r = 2'd0;
        c = 2'd0;
        case (step_reg)
            5'd0:    begin r = rmap[1]; c = cmap[1]; end
            5'd1:    begin r = rmap[2]; c = cmap[2]; end
            5'd2:    begin r = rmap[1]; c = cmap[2]; end
            5'd3:    begin r = rmap[2]; c = cmap[1]; end
            5'd4:    begin r = rmap[1]; c = cmap[0]; end
            5'd5:    begin r = rmap[2]; c = cmap[2]; end
            5'd6:    begin r = rmap[1]; c = cmap[2]; end
            5'd7:    begin r = rmap[2]; c = cmap[0]; end
            5'd8:    begin r = rmap[1]; c = cmap[0]; end
            5'd9:    begin r = rmap[2]; c = cmap[1]; end
            5'd10:   begin r = rmap[1]; c = cmap[1]; end
            5'd11:   begin r = rmap[2]; c = cmap[0]; end
            5'd12:   begin r = rmap[0]; c = cmap[0]; end
            5'd13:   begin r = rmap[0]; c = cmap[1]; end
            5'd14:   begin r = rmap[0]; c = cmap[2]; end
            default: begin r = ci; c = 2'd0; end
        endcase
        raddr = {r, c};
    end

    function automatic logic signed [31:0] sat(input logic signed [63:0] v);
        if (v > m4inv_pkg::S32_MAX)
        begin
            return 32'sh7fffffff;
        end
        else if (v < m4inv_pkg::S32_MIN)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    assign sum_sat_in = ci[0] ^ cj[0] ? -acc_reg : acc_reg;
    assign minor_diff = acc_reg - prod;
    assign minor_sat  = sat(minor_diff);

    logic        q_neg;
    assign q_neg = cof_reg[31] ^ det_reg[63];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            phase_reg     <= 1'b0;
            k_reg         <= '0;
            step_reg      <= '0;
            m_tvalid      <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (m_tvalid && m_tready && state_reg != ST_EMIT)
            begin
                m_tvalid <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (s_tvalid && s_tlast)
                    begin
                        state_reg    <= ST_COF;
                        phase_reg    <= 1'b0;
                        k_reg        <= '0;
                        step_reg     <= '0;
                        det_reg      <= '0;
                        det_clip_reg <= 1'b0;
                        clip_reg     <= 1'b0;
                    end
                end
                ST_COF:
                begin
                    step_reg <= step_reg + 5'd1;
                    // Operand capture from the registered RAM read data.
                    case (step_reg) inside
                        5'd1, 5'd5, 5'd9: a_reg <= rdata;
                        5'd2, 5'd6, 5'd10: b_reg <= rdata;
                        5'd3, 5'd7, 5'd11: a_reg <= rdata;
                        5'd4, 5'd8, 5'd12: b_reg <= rdata;
                        5'd13: begin a_reg <= rdata; b_reg <= m0_reg; end
                        5'd14: begin a_reg <= rdata; b_reg <= m1_reg; end
                        5'd15: begin a_reg <= rdata; b_reg <= m2_reg; end
                        5'd16: begin a_reg <= rdata; end
                        default: ;
                    endcase
                    // Products pass through the multiplier's product register, then are rounded and captured here.
                    case (step_reg) inside
                        5'd4, 5'd8, 5'd12: acc_reg <= prod;
                        5'd6:
                        begin
                            m0_reg   <= minor_sat;
                            clip_reg <= clip_reg | (64'(minor_sat) != minor_diff);
                        end
                        5'd10:
                        begin
                            m1_reg   <= minor_sat;
                            clip_reg <= clip_reg | (64'(minor_sat) != minor_diff);
                        end
                        5'd14:
                        begin
                            m2_reg   <= minor_sat;
                            clip_reg <= clip_reg | (64'(minor_sat) != minor_diff);
                        end
                        5'd15: acc_reg <= prod;
                        5'd16: acc_reg <= acc_reg - prod;
                        5'd17: acc_reg <= acc_reg + prod;
                        5'd18:
                        begin
                            cof_reg  <= sat(sum_sat_in);
                            clip_reg <= clip_reg | (64'(sat(sum_sat_in)) != sum_sat_in);
                            b_reg    <= sat(sum_sat_in);
                            state_reg <= phase_reg ? ST_DIVSTART : ST_DETACC;
                        end
                        default: ;
                    endcase
                end
                ST_DETACC:
                begin
                    if (step_reg == 5'd22)
                    begin
                        det_reg      <= det_reg + prod;
                        det_clip_reg <= det_clip_reg | clip_reg;
                        clip_reg     <= 1'b0;
                        step_reg     <= '0;
                        state_reg    <= ST_COF;
                        if (k_reg == 4'd3)
                        begin
                            phase_reg <= 1'b1;
                            k_reg     <= '0;
                        end
                        else
                        begin
                            k_reg <= k_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_DIVSTART:
                begin
                    if (det_reg == 64'sd0)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIVWAIT;
                    end
                end
                ST_DIVWAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!m_tvalid || m_tready)
                    begin
                        m_tvalid <= 1'b1;
                        m_tlast  <= (k_reg == 4'd15);
                        m_tdata[3:0] <= {k_reg[1:0], k_reg[3:2]};
                        m_tdata[39:36] <= '0;
                        if (det_reg == 64'sd0)
                        begin
                            m_tdata[35:4] <= '0;
                            m_tuser <= 2'b01;
                        end
                        else if (q_neg)
                        begin
                            m_tdata[35:4] <= (quot > 64'h80000000) ? 32'h80000000 :
                                             32'd0 - quot[31:0];
                            m_tuser <= {clip_reg | det_clip_reg |
                                        (quot > 64'h80000000), 1'b0};
                        end
                        else
                        begin
                            m_tdata[35:4] <= (quot > 64'h7fffffff) ? 32'h7fffffff :
                                             quot[31:0];
                            m_tuser <= {clip_reg | det_clip_reg |
                                        (quot > 64'h7fffffff), 1'b0};
                        end
                        clip_reg <= 1'b0;
                        step_reg <= '0;
                        k_reg    <= k_reg + 4'd1;
                        state_reg <= (k_reg == 4'd15) ? ST_HOLD : ST_COF;
                    end
                end
                ST_HOLD:
                begin
                    if (!m_tvalid || m_tready)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    // Output index k maps to row k[3:2], col k[1:0]; cofactor (col,row) = (k[1:0],k[3:2]).
    assign s_tready = (state_reg == ST_LOAD);

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !s_tready)
        else $error("input accepted during a run");
    a_last_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |-> (state_reg == ST_HOLD || state_reg == ST_LOAD))
        else $error("last result outside the final phase");
    a_div_only_nonsingular: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> (det_reg != 64'sd0))
        else $error("divider started on a zero determinant");

endmodule
